[src/soft_switch_io_with_paddle_timers_defines.svh]
// assertion macros shared by the soft switch i/o block
`ifndef SOFT_SWITCH_IO_WITH_PADDLE_TIMERS_DEFINES_SVH
`define SOFT_SWITCH_IO_WITH_PADDLE_TIMERS_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SSIO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SSIO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ssio_pkg.sv]
`default_nettype none
package ssio_pkg;

  localparam int unsigned NUM_PADDLES_DEF = 4;
  localparam int unsigned NUM_BUTTONS     = 3;
  localparam int unsigned PADDLE_W        = 15;

  typedef enum logic [2:0] {
    REQ_READ       = 3'd0,
    REQ_WRITE      = 3'd1,
    REQ_TICK       = 3'd2,
    REQ_SET_KEY    = 3'd3,
    REQ_SET_PADDLE = 3'd4,
    REQ_SET_BUTTON = 3'd5
  } req_t;

  // built-in space groups, io_addr bits 6..4
  localparam logic [2:0] GRP_KEY     = 3'd0;
  localparam logic [2:0] GRP_KEY_CLR = 3'd1;
  localparam logic [2:0] GRP_VIDEO   = 3'd5;
  localparam logic [2:0] GRP_GAME    = 3'd6;
  localparam logic [2:0] GRP_STROBE  = 3'd7;

  // slot number of the disk controller
  localparam logic [2:0] SLOT_DISK = 3'd6;

  localparam logic [7:0] RD_PROM   = 8'hff;
  localparam logic [7:0] RD_DEVICE = 8'hee;
  localparam logic [7:0] RD_BIT7   = 8'h80;

  typedef struct packed {
    logic [2:0]          req_type;
    logic [10:0]         io_addr;
    logic [7:0]          wdata;
    logic [1:0]          unit_index;
    logic [PADDLE_W-1:0] paddle_value;
    logic                button_level;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       gfx_mode;
    logic       mixed_mode;
    logic       page_two;
    logic       hires_mode;
    logic       slot6_access;
    logic [3:0] slot6_reg;
  } out_beat_t;

endpackage
`default_nettype wire

[src/soft_switch_io_with_paddle_timers.sv]
`default_nettype none
// I/O page soft switch decoder with game port paddle timers. Each input beat
// (bus read or write, tick, key, paddle or button update) yields exactly one
// result beat carrying read data, the four video flags as they stand after
// the beat, and a slot 6 flag with register offset for an outside disk unit,
// which substitutes its own read data when the flag is set. A beat passes an
// input register, then the decode and state update, then a result register:
// one beat is taken every cycle, and the rate drops only while out_stall
// holds the result register full.
`include "soft_switch_io_with_paddle_timers_defines.svh"
module soft_switch_io_with_paddle_timers #(
  parameter int unsigned NUM_PADDLES = ssio_pkg::NUM_PADDLES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ssio_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ssio_pkg::out_beat_t      out_data
);

  logic                item_vld;
  ssio_pkg::in_beat_t  item;
  ssio_pkg::out_beat_t result;
  logic                ready;
  logic                adv;

  assign adv = item_vld && ready;

  ssio_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .adv      (adv),
    .item_vld (item_vld),
    .item     (item)
  );

  ssio_core #(
    .NUM_PADDLES (NUM_PADDLES)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .item   (item),
    .result (result)
  );

  ssio_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .result    (result),
    .ready     (ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `SSIO_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid && out_stall, "input stall without a held result")
  `SSIO_ASSERT_NEXT(a_item_moves_on, item_vld && !out_stall, out_valid, "pending beat did not reach result register")
  `SSIO_ASSERT_NOW(a_slot6_reg_clear, out_valid && !out_data.slot6_access, out_data.slot6_reg == 4'd0, "slot6_reg set without slot6_access")

endmodule
`default_nettype wire

[src/ssio_in_reg.sv]
`default_nettype none
module ssio_in_reg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ssio_pkg::in_beat_t in_data,
  input  wire logic               adv,
  output logic                    item_vld,
  output ssio_pkg::in_beat_t      item
);

  logic               vld_r;
  logic               vld_nxt;
  ssio_pkg::in_beat_t data_r;
  logic               accept;

  assign in_stall = vld_r && !adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_data;
    end
  end

  assign item_vld = vld_r;
  assign item     = data_r;

endmodule
`default_nettype wire

[src/ssio_core.sv]
`default_nettype none
module ssio_core #(
  parameter int unsigned NUM_PADDLES = ssio_pkg::NUM_PADDLES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire ssio_pkg::in_beat_t item,
  output ssio_pkg::out_beat_t     result
);

  localparam int unsigned PW = ssio_pkg::PADDLE_W;
  localparam int unsigned NB = ssio_pkg::NUM_BUTTONS;

  logic [7:0]          key_r,   key_nxt;
  logic [3:0]          flags_r, flags_nxt;
  logic [NB-1:0]       btn_r,   btn_nxt;
  logic [PW-1:0]       set_r    [NUM_PADDLES];
  logic [PW-1:0]       set_nxt  [NUM_PADDLES];
  logic [PW-1:0]       tmr_r    [NUM_PADDLES];
  logic [PW-1:0]       tmr_nxt  [NUM_PADDLES];
  logic [NUM_PADDLES-1:0] busy_r, busy_nxt;

  logic [7:0] rd;
  logic       s6;
  logic       touch;
  logic       is_read;
  logic       sel_bit;
  logic [2:0] grp;
  logic [2:0] sw;

  assign grp     = item.io_addr[6:4];
  assign sw      = item.io_addr[3:1];
  assign is_read = (item.req_type == ssio_pkg::REQ_READ);

  always_comb begin
    logic [PW-1:0] tdec;
    key_nxt   = key_r;
    flags_nxt = flags_r;
    btn_nxt   = btn_r;
    set_nxt   = set_r;
    tmr_nxt   = tmr_r;
    busy_nxt  = busy_r;
    rd        = '0;
    s6        = 1'b0;
    touch     = 1'b0;
    sel_bit   = 1'b0;
    tdec      = '0;

    unique case (item.req_type) inside
      ssio_pkg::REQ_READ, ssio_pkg::REQ_WRITE: begin
        if (item.io_addr[10:8] != 3'd0) begin
          // card prom space
          if (is_read) begin
            rd = ssio_pkg::RD_PROM;
            s6 = (item.io_addr[10:8] == ssio_pkg::SLOT_DISK);
          end
        end else if (item.io_addr[7]) begin
          // card device registers
          if (is_read) begin
            rd = ssio_pkg::RD_DEVICE;
          end
          s6 = (grp == ssio_pkg::SLOT_DISK);
        end else begin
          touch = 1'b1;
          if (is_read) begin
            if (grp == ssio_pkg::GRP_KEY) begin
              rd = key_r;
            end else if (grp == ssio_pkg::GRP_GAME) begin
              for (int j = 0; j < NB; j++) begin
                if (item.io_addr[2:0] == 3'(j + 1)) begin
                  sel_bit = btn_r[j];
                end
              end
              for (int i = 0; i < NUM_PADDLES; i++) begin
                if (item.io_addr[2] && (item.io_addr[1:0] == 2'(i))) begin
                  sel_bit = busy_r[i];
                end
              end
              rd = sel_bit ? ssio_pkg::RD_BIT7 : 8'h00;
            end
          end
        end
      end
      ssio_pkg::REQ_TICK: begin
        if (busy_r != '0) begin
          for (int i = 0; i < NUM_PADDLES; i++) begin
            tdec = (tmr_r[i] != '0) ? (tmr_r[i] - PW'(1)) : tmr_r[i];
            tmr_nxt[i] = tdec;
            if (tdec == '0) begin
              busy_nxt[i] = 1'b0;
            end
          end
        end
      end
      ssio_pkg::REQ_SET_KEY: begin
        key_nxt = item.wdata;
      end
      ssio_pkg::REQ_SET_PADDLE: begin
        for (int i = 0; i < NUM_PADDLES; i++) begin
          if (item.unit_index == 2'(i)) begin
            set_nxt[i] = item.paddle_value;
          end
        end
      end
      ssio_pkg::REQ_SET_BUTTON: begin
        for (int j = 0; j < NB; j++) begin
          if (item.unit_index == 2'(j)) begin
            btn_nxt[j] = item.button_level;
          end
        end
      end
      default: begin
      end
    endcase

    // soft switch side effects of a built-in reference
    if (touch) begin
      case (grp)
        ssio_pkg::GRP_KEY_CLR: begin
          key_nxt[7] = 1'b0;
        end
        ssio_pkg::GRP_VIDEO: begin
          if (!sw[2]) begin
            flags_nxt[sw[1:0]] = (sw == 3'd0) ? !item.io_addr[0] : item.io_addr[0];
          end
        end
        ssio_pkg::GRP_STROBE: begin
          busy_nxt = '1;
          tmr_nxt  = set_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      flags_r <= '0;
      btn_r   <= '0;
      set_r   <= '{default: '0};
      tmr_r   <= '{default: '0};
      busy_r  <= '0;
    end else if (adv) begin
      key_r   <= key_nxt;
      flags_r <= flags_nxt;
      btn_r   <= btn_nxt;
      set_r   <= set_nxt;
      tmr_r   <= tmr_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_comb begin
    result.rdata        = rd;
    result.gfx_mode     = flags_nxt[0];
    result.mixed_mode   = flags_nxt[1];
    result.page_two     = flags_nxt[2];
    result.hires_mode   = flags_nxt[3];
    result.slot6_access = s6;
    result.slot6_reg    = s6 ? item.io_addr[3:0] : 4'd0;
  end

endmodule
`default_nettype wire

[src/ssio_out_reg.sv]
`default_nettype none
module ssio_out_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire ssio_pkg::out_beat_t result,
  output logic                     ready,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ssio_pkg::out_beat_t      out_data
);

  logic                vld_r;
  logic                vld_nxt;
  ssio_pkg::out_beat_t data_r;

  assign ready = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire
